/* hw/rtl/rgb555_sprite_pixel_compositor_assert.svh */
// Assertion macros for the RGB555 sprite pixel compositor.
// Expects clk and arst_n in the scope of use; define ASSERT_OFF to drop all checks.
`ifndef RGB555_SPRITE_PIXEL_COMPOSITOR_ASSERT_SVH
`define RGB555_SPRITE_PIXEL_COMPOSITOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SPC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spc assertion failed");
// next-cycle implication
`define SPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spc assertion failed");
`else
`define SPC_ASSERT_IMPL(label, ante, cons)
`define SPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/spc_pkg.sv */
// Shared types and constants for the RGB555 sprite pixel compositor.
// No dependencies; used by spc_cfg_regs, spc_pix_math and the top level.
package spc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_AMOUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_USE_MASK_PLANE = 3'd4;

	localparam logic [5:0] AMOUNT_FULL    = 6'd32;
	localparam logic [9:0] MASK_INVISIBLE = 10'd1000;

	typedef enum logic [1:0] {
		DRAW_COPY,
		DRAW_ALPHA,
		DRAW_SHADOW,
		DRAW_TINT
	} draw_mode_t;

	typedef struct packed {
		draw_mode_t  draw_mode;
		logic [5:0]  effect_amount;
		logic [15:0] tint_color;
		logic [15:0] key_color;
		logic        use_mask_plane;
	} cfg_t;

endpackage

/* hw/rtl/rgb555_sprite_pixel_compositor.sv */
// Top level of the RGB555 sprite pixel compositor: input register, pixel math, result register.
// Depends on spc_pkg, spc_cfg_regs, spc_pix_math and the assertion macro header.
//
// Usage:
//  - s_* channel: one item per destination pixel (dest, source, mask). Items are
//    independent; one item per clock is sustained while m_tready stays high.
//  - m_* channel: one result item per input item, in order: new pixel and write flag.
//    When the flag is low the pixel equals the incoming destination pixel.
//  - cfg_* port: write draw mode, effect amount, tint color, key color and mask plane
//    enable by index. Write only while no item is in flight.
//  - Path: an accepted item shows on m_tvalid once it has passed both registers
//    (two registers: input stage _s1, result stage _s2, math in between).
//  - Throughput: 1 item per cycle while m_tready stays high; set by the two-stage
//    register pipeline, nothing iterates.
//  - Stall: when m_tready is low the result stage holds; the input stage still fills,
//    so up to two items are held before s_tready drops. s_tready is combinational
//    from m_tready.
//  - Reset (arst_n low): both stages empty, all config registers read zero
//    (copy mode, no effect, color key 0, mask plane off).
`include "rgb555_sprite_pixel_compositor_assert.svh"

module rgb555_sprite_pixel_compositor import spc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // [15:0] dest_pixel, [31:16] source_pixel,
	                                         // [41:32] mask_value, [47:42] zero
	// result items
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata    // [15:0] new_pixel, [16] write_enable,
	                                         // [23:17] zero
);

	cfg_t cfg;

	logic        valid_s1;
	logic [15:0] dest_s1;
	logic [15:0] src_s1;
	logic [9:0]  mask_s1;

	logic        valid_s2;
	logic [15:0] pix_s2;
	logic        wen_s2;

	logic [15:0] pix_c;
	logic        wen_c;
	logic        adv_s2;

	spc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result stage can load when empty or being drained
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dest_s1 <= s_tdata[15:0];
			src_s1  <= s_tdata[31:16];
			mask_s1 <= s_tdata[41:32];
		end
	end

	spc_pix_math u_math (
		.cfg          (cfg),
		.dest_pixel   (dest_s1),
		.source_pixel (src_s1),
		.mask_value   (mask_s1),
		.new_pixel    (pix_c),
		.write_enable (wen_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			pix_s2 <= pix_c;
			wen_s2 <= wen_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, wen_s2, pix_s2};

	// a full pipe under stall must refuse new input
	`SPC_ASSERT_IMPL(a_no_overrun, valid_s1 && valid_s2 && !m_tready, !s_tready)
	// an item leaving the input stage lands in the result stage
	`SPC_ASSERT_NEXT(a_s1_to_s2, valid_s1 && adv_s2, valid_s2)
	// full effect amount never produces a write
	`SPC_ASSERT_IMPL(a_full_amount_no_write,
		valid_s2 && cfg.effect_amount == AMOUNT_FULL, !wen_s2)
	// blended and shaded results clear the top bit
	`SPC_ASSERT_IMPL(a_bit15_clear,
		valid_s2 && wen_s2 && cfg.draw_mode != DRAW_COPY, !pix_s2[15])

endmodule

/* hw/rtl/spc_cfg_regs.sv */
// Configuration register file for the sprite compositor.
// Depends on spc_pkg (cfg_t, register indexes).
module spc_cfg_regs import spc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DRAW_MODE:      cfg_q.draw_mode      <= draw_mode_t'(cfg_data[1:0]);
				REG_EFFECT_AMOUNT:  cfg_q.effect_amount  <= cfg_data[5:0];
				REG_TINT_COLOR:     cfg_q.tint_color     <= cfg_data;
				REG_KEY_COLOR:      cfg_q.key_color      <= cfg_data;
				REG_USE_MASK_PLANE: cfg_q.use_mask_plane <= cfg_data[0];
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/spc_pix_math.sv */
// Per-pixel visibility, blend and shade logic between the input and result registers.
// Depends on spc_pkg (cfg_t, draw modes, constants).
module spc_pix_math import spc_pkg::*; (
	input  cfg_t        cfg,
	input  logic [15:0] dest_pixel,
	input  logic [15:0] source_pixel,
	input  logic [9:0]  mask_value,
	output logic [15:0] new_pixel,
	output logic        write_enable
);

	// trunc(0.032*m*m) == floor(4*m*m/125) for m in 0..31
	function automatic logic [4:0] shadow_rom(input logic [4:0] m);
		logic [4:0] r;
		case (m)
			5'd6, 5'd7:   r = 5'd1;
			5'd8, 5'd9:   r = 5'd2;
			5'd10, 5'd11: r = 5'd3;
			5'd12: r = 5'd4;
			5'd13: r = 5'd5;
			5'd14: r = 5'd6;
			5'd15: r = 5'd7;
			5'd16: r = 5'd8;
			5'd17: r = 5'd9;
			5'd18: r = 5'd10;
			5'd19: r = 5'd11;
			5'd20: r = 5'd12;
			5'd21: r = 5'd14;
			5'd22: r = 5'd15;
			5'd23: r = 5'd16;
			5'd24: r = 5'd18;
			5'd25: r = 5'd20;
			5'd26: r = 5'd21;
			5'd27: r = 5'd23;
			5'd28: r = 5'd25;
			5'd29: r = 5'd26;
			5'd30: r = 5'd28;
			5'd31: r = 5'd30;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// (d*t + s*(32-t)) >> 5 for one 5-bit channel
	function automatic logic [4:0] ch_blend(input logic [4:0] d, input logic [4:0] s,
			input logic [4:0] t);
		logic [5:0]  u;
		logic [10:0] acc;
		u   = AMOUNT_FULL - {1'b0, t};
		acc = ({6'b0, d} * {6'b0, t}) + ({6'b0, s} * {5'b0, u});
		return acc[9:5];
	endfunction

	function automatic logic [4:0] ch_shade(input logic [4:0] d, input logic [4:0] f);
		logic [9:0] p;
		p = {5'b0, d} * {5'b0, f};
		return p[9:5];
	endfunction

	logic       visible;
	logic [4:0] m;
	logic [6:0] e_amt;     // effect amount plus mask
	logic [6:0] f_amt;     // shadow factor
	logic [4:0] t_sel;
	logic [15:0] op_sel;
	logic [14:0] blend_pix;
	logic [14:0] shade_pix;

	always_comb begin
		visible = 1'b1;
		m       = '0;
		if (cfg.effect_amount == AMOUNT_FULL) begin
			visible = 1'b0;
		end else if (cfg.use_mask_plane) begin
			if (mask_value == MASK_INVISIBLE || mask_value >= 10'(AMOUNT_FULL)) begin
				visible = 1'b0;
			end else begin
				m = mask_value[4:0];
			end
		end else if (source_pixel == cfg.key_color) begin
			visible = 1'b0;
		end
	end

	assign e_amt = {1'b0, cfg.effect_amount} + {2'b0, m};
	assign f_amt = {1'b0, cfg.effect_amount} + {2'b0, shadow_rom(m)};

	// one shared blender: copy mode weights by mask, alpha/tint by effective amount
	always_comb begin
		t_sel  = e_amt[4:0];
		op_sel = source_pixel;
		case (cfg.draw_mode)
			DRAW_COPY: t_sel  = m;
			DRAW_TINT: op_sel = cfg.tint_color;
			default: ;
		endcase
	end

	assign blend_pix = {ch_blend(dest_pixel[14:10], op_sel[14:10], t_sel),
	                    ch_blend(dest_pixel[9:5],   op_sel[9:5],   t_sel),
	                    ch_blend(dest_pixel[4:0],   op_sel[4:0],   t_sel)};

	assign shade_pix = {ch_shade(dest_pixel[14:10], f_amt[4:0]),
	                    ch_shade(dest_pixel[9:5],   f_amt[4:0]),
	                    ch_shade(dest_pixel[4:0],   f_amt[4:0])};

	always_comb begin
		new_pixel    = dest_pixel;
		write_enable = 1'b0;
		if (visible) begin
			case (cfg.draw_mode)
				DRAW_COPY: begin
					new_pixel    = (m == 5'd0) ? source_pixel : {1'b0, blend_pix};
					write_enable = 1'b1;
				end
				DRAW_SHADOW: begin
					if (f_amt < 7'(AMOUNT_FULL)) begin
						new_pixel    = {1'b0, shade_pix};
						write_enable = 1'b1;
					end
				end
				default: begin
					if (e_amt < 7'(AMOUNT_FULL)) begin
						new_pixel    = {1'b0, blend_pix};
						write_enable = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

/* tb/tb_rgb555_sprite_pixel_compositor.sv */
`timescale 1ns / 1ps
// Self-checking bench for rgb555_sprite_pixel_compositor: a directed table and then random items.
// Depends on spc_pkg and the compositor RTL. An in-bench pixel predictor supplies expected results.
module tb_rgb555_sprite_pixel_compositor;
	import spc_pkg::*;

	// expected result of one pixel item
	typedef struct packed {
		logic [15:0] pixel;
		logic        written;
	} pix_result_t;

	// one directed item, with the register settings it runs under
	typedef struct packed {
		cfg_t        cfg;
		logic [15:0] dest;
		logic [15:0] src;
		logic [9:0]  mask;
		logic        typed;     // 1: expected result typed in below
		logic [15:0] exp_pixel;
		logic        exp_written;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;   // [15:0] dest_pixel, [31:16] source_pixel,
	                                  // [41:32] mask_value, [47:42] zero
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // [15:0] new_pixel, [16] write_enable, [23:17] zero

	rgb555_sprite_pixel_compositor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// bench copy of the register file; changes only while the pipe is empty
	cfg_t        cur_cfg;
	pix_result_t pending_pixels[$];

	int tx_idle_pct;   // chance per cycle that the sender holds back
	int rx_stall_pct;  // chance per cycle that the receiver stalls
	bit hold_req;      // asks the receiver for one long hold-off
	int hold_len;

	int error_count;
	int items_sent;
	int results_seen;
	int settings_count;
	int writes_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: even the slowest legal run ends well before this.
	initial begin
		#5_000_000;
		$display("Timeout: %0d items sent, %0d results seen", items_sent, results_seen);
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// per channel (d*t + s*(32-t)) >> 5 over the three 5-bit fields; bit 15 cleared
	function automatic logic [15:0] mix555(logic [15:0] d, logic [15:0] s, int t);
		logic [15:0] mixed;
		int dc;
		int sc;
		mixed = '0;
		for (int k = 0; k < 3; k++) begin
			dc = (d >> (5 * k)) & 31;
			sc = (s >> (5 * k)) & 31;
			mixed[5*k +: 5] = 5'((dc * t + sc * (32 - t)) >> 5);
		end
		return mixed;
	endfunction

	function automatic pix_result_t predict_composite(cfg_t c, logic [15:0] d, logic [15:0] s,
			logic [9:0] mraw);
		pix_result_t r;
		bit show;
		int m;
		int e;
		int f;
		int dc;
		r.pixel   = d;
		r.written = 1'b0;
		show      = 1'b1;
		m         = 0;
		// full amount blanks every mode; then either the mask plane or the color key decides
		if (c.effect_amount == AMOUNT_FULL)
			show = 1'b0;
		else if (c.use_mask_plane) begin
			if (mraw == MASK_INVISIBLE || mraw >= 10'(AMOUNT_FULL))
				show = 1'b0;
			else
				m = int'(mraw);
		end else if (s == c.key_color)
			show = 1'b0;

		if (show) begin
			e = int'(c.effect_amount) + m;
			// shadow ROM term: trunc(0.032*m*m) is exactly floor(4*m*m/125) for m < 32
			f = int'(c.effect_amount) + (4 * m * m) / 125;
			case (c.draw_mode)
				DRAW_COPY: begin
					r.pixel   = (m == 0) ? s : mix555(d, s, m);
					r.written = 1'b1;
				end
				DRAW_ALPHA: if (e < 32) begin
					r.pixel   = mix555(d, s, e);
					r.written = 1'b1;
				end
				DRAW_SHADOW: if (f < 32) begin
					r.pixel = '0;
					for (int k = 0; k < 3; k++) begin
						dc = (d >> (5 * k)) & 31;
						r.pixel[5*k +: 5] = 5'((dc * f) >> 5);
					end
					r.written = 1'b1;
				end
				default: if (e < 32) begin
					r.pixel   = mix555(d, c.tint_color, e);
					r.written = 1'b1;
				end
			endcase
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at result %0d: %s got %h want %h", results_seen, what, got, want);
		error_count++;
	endtask

	// Stop offering items and wait until every expected result has come back.
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Write all five registers on back-to-back edges; pipe must be empty.
	task automatic apply_settings(cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DRAW_MODE;
		cfg_data  <= CFG_DATA_W'(c.draw_mode);
		@(posedge clk);
		cfg_index <= REG_EFFECT_AMOUNT;
		cfg_data  <= CFG_DATA_W'(c.effect_amount);
		@(posedge clk);
		cfg_index <= REG_TINT_COLOR;
		cfg_data  <= c.tint_color;
		@(posedge clk);
		cfg_index <= REG_KEY_COLOR;
		cfg_data  <= c.key_color;
		@(posedge clk);
		cfg_index <= REG_USE_MASK_PLANE;
		cfg_data  <= CFG_DATA_W'(c.use_mask_plane);
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_cfg = c;
		settings_count++;
	endtask

	// Offer one pixel item; queue its expected result once the handshake completes.
	// s_tvalid stays high on return so back-to-back items need no bubble.
	task automatic send_pixel(logic [15:0] d, logic [15:0] s, logic [9:0] mk, bit typed,
			pix_result_t typed_res);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, mk, s, d};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_pixels = {pending_pixels,
			(typed ? typed_res : predict_composite(cur_cfg, d, s, mk))};
		items_sent++;
	endtask

	// Receiver: random stalls per phase, plus one long hold-off counted here.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = hold_len;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ---------------------------------------------------------------- checking

	// Inputs change only after edges, so sampling here sees settled pre-edge values.
	always @(posedge clk) begin : result_check
		pix_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_pixels.size() == 0)
				report_mismatch("result with nothing pending", 32'(m_tdata), 32'h0);
			else begin
				want = pending_pixels.pop_front();
				if (m_tdata[15:0] !== want.pixel)
					report_mismatch("new_pixel", 32'(m_tdata[15:0]), 32'(want.pixel));
				if (m_tdata[16] !== want.written)
					report_mismatch("write_enable", 32'(m_tdata[16]), 32'(want.written));
				if (want.written)
					writes_seen++;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	stim_row_t directed_rows[23];
	int        idle_tx_by_phase[4];
	int        idle_rx_by_phase[4];

	initial begin
		stim_row_t   row;
		cfg_t        c;
		pix_result_t typed_res;
		logic [15:0] d;
		logic [15:0] s;
		logic [9:0]  mk;
		int          phase;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		tx_idle_pct    = 0;
		rx_stall_pct   = 0;
		hold_req       = 1'b0;
		hold_len       = 0;
		error_count    = 0;
		items_sent     = 0;
		results_seen   = 0;
		settings_count = 0;
		writes_seen    = 0;
		cur_cfg        = '0;   // register file after reset

		// phases: none, sender idle, receiver stall, both
		idle_tx_by_phase = '{0, 83, 0, 26};
		idle_rx_by_phase = '{0, 0, 83, 26};

		// cfg fields: mode, amount, tint, key, mask plane
		directed_rows = '{
			// after reset: source equal to key 0 is dropped, anything else copied
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b0}, 16'h1234, 16'h0000, 10'd0,
				1'b1, 16'h1234, 1'b0},
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b0}, 16'h0000, 16'hFFFF, 10'h3FF,
				1'b1, 16'hFFFF, 1'b1},
			// mask plane: opaque copy keeps bit 15, invisible masks, partial blends
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h7FFF, 16'h8001, 10'd0,
				1'b1, 16'h8001, 1'b1},
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h2AAA, 16'h1234, 10'd1000,
				1'b1, 16'h2AAA, 1'b0},
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h5555, 16'h1234, 10'd32,
				1'b1, 16'h5555, 1'b0},
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h0001, 16'h1234, 10'd1023,
				1'b1, 16'h0001, 1'b0},
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h7FFF, 16'h0000, 10'd31,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_COPY, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h0000, 16'h7FFF, 10'd1,
				1'b0, 16'h0, 1'b0},
			// full amount blanks even copy mode; amounts above it are ignored by copy mode
			'{'{DRAW_COPY, 6'd32, 16'h0000, 16'h0000, 1'b0}, 16'h4321, 16'hFFFF, 10'd0,
				1'b1, 16'h4321, 1'b0},
			'{'{DRAW_COPY, 6'd63, 16'h0000, 16'h0005, 1'b0}, 16'h0000, 16'hFFFF, 10'd0,
				1'b1, 16'hFFFF, 1'b1},
			// overall transparency
			'{'{DRAW_ALPHA, 6'd0, 16'h0000, 16'h0005, 1'b0}, 16'hFFFF, 16'h8000, 10'd0,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_ALPHA, 6'd31, 16'h0000, 16'h0000, 1'b1}, 16'h7FFF, 16'h0000, 10'd0,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_ALPHA, 6'd16, 16'h0000, 16'h0000, 1'b1}, 16'h1111, 16'h7FFF, 10'd16,
				1'b1, 16'h1111, 1'b0},
			'{'{DRAW_ALPHA, 6'd33, 16'h0000, 16'h0000, 1'b0}, 16'h2222, 16'h0001, 10'd0,
				1'b1, 16'h2222, 1'b0},
			'{'{DRAW_ALPHA, 6'd1, 16'h0000, 16'h0000, 1'b0}, 16'hFFFF, 16'hFFFF, 10'd0,
				1'b0, 16'h0, 1'b0},
			// shadow: ROM term at the top mask, amount at the top, overflow, full amount
			'{'{DRAW_SHADOW, 6'd0, 16'h0000, 16'h0000, 1'b1}, 16'h7FFF, 16'h1234, 10'd31,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_SHADOW, 6'd31, 16'h0000, 16'h0000, 1'b1}, 16'hFFFF, 16'h1234, 10'd0,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_SHADOW, 6'd10, 16'h0000, 16'h0000, 1'b1}, 16'h3333, 16'h1234, 10'd31,
				1'b1, 16'h3333, 1'b0},
			'{'{DRAW_SHADOW, 6'd32, 16'h0000, 16'h0000, 1'b1}, 16'h4444, 16'h1234, 10'd0,
				1'b1, 16'h4444, 1'b0},
			// solid color tint
			'{'{DRAW_TINT, 6'd0, 16'hFFFF, 16'h0000, 1'b0}, 16'h0000, 16'h1234, 10'd0,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_TINT, 6'd5, 16'h7C1F, 16'h0000, 1'b1}, 16'h03E0, 16'h1234, 10'd26,
				1'b0, 16'h0, 1'b0},
			'{'{DRAW_TINT, 6'd31, 16'hFFFF, 16'hFFFF, 1'b0}, 16'h5A5A, 16'hFFFF, 10'd0,
				1'b1, 16'h5A5A, 1'b0},
			'{'{DRAW_TINT, 6'd6, 16'hFFFF, 16'hFFFF, 1'b1}, 16'h0F0F, 16'hFFFF, 10'd26,
				1'b1, 16'h0F0F, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: settings change only with the pipe empty.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg != cur_cfg) begin
				drain_pipe();
				apply_settings(row.cfg);
			end
			typed_res.pixel   = row.exp_pixel;
			typed_res.written = row.exp_written;
			send_pixel(row.dest, row.src, row.mask, row.typed, typed_res);
		end
		drain_pipe();

		// Random part: 12 segments of 138 items, each under its own settings and idle phase.
		typed_res = '0;
		for (int seg = 0; seg < 12; seg++) begin
			drain_pipe();
			if (seg == 0)
				c = '0;
			else if (seg == 11)
				c = '{DRAW_TINT, 6'd31, 16'hFFFF, 16'hFFFF, 1'b1};
			else begin
				c.draw_mode = draw_mode_t'($urandom_range(3));
				// amounts mostly small so blend modes still write; extremes now and then
				case ($urandom_range(9))
					0:       c.effect_amount = 6'd0;
					1:       c.effect_amount = 6'd31;
					2:       c.effect_amount = AMOUNT_FULL;
					3:       c.effect_amount = 6'($urandom_range(63, 33));
					4, 5:    c.effect_amount = 6'($urandom_range(31, 16));
					default: c.effect_amount = 6'($urandom_range(15));
				endcase
				c.tint_color     = 16'($urandom);
				c.key_color      = 16'($urandom);
				c.use_mask_plane = 1'($urandom);
			end
			apply_settings(c);

			phase        = seg % 4;
			tx_idle_pct  = idle_tx_by_phase[phase];
			rx_stall_pct = idle_rx_by_phase[phase];

			// long receiver hold-off while items keep coming: the pipe fills and s_tready drops
			if (seg == 4) begin
				hold_len = 300;
				hold_req = 1'b1;
			end

			for (int n = 0; n < 138; n++) begin
				d = 16'($urandom);
				s = ($urandom_range(7) == 0) ? cur_cfg.key_color : 16'($urandom);
				case ($urandom_range(9))
					0:       mk = MASK_INVISIBLE;
					1:       mk = 10'($urandom_range(1023));
					2:       mk = 10'd0;
					default: mk = 10'($urandom_range(31));
				endcase
				send_pixel(d, s, mk, 1'b0, typed_res);
			end
		end

		drain_pipe();
		// a few more edges so a stray extra result would still be caught
		repeat (4) @(posedge clk);

		$display("Covered %0d items under %0d register settings; %0d results, %0d writes.",
			items_sent, settings_count, results_seen, writes_seen);
		$display("All four draw modes, mask plane and color key, amount extremes, stalls.");
		if (error_count == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches", error_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
